/* sv/assert_macros.svh */
// assertion helpers for the route move step unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ARMS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define ARMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/arms_pkg.sv */
`default_nettype none
package arms_pkg;

  localparam int ROUTE_SLOTS_DEF   = 3;
  localparam int MAX_ROUTES_DEF    = 8;
  localparam int MAX_CUSTOMERS_DEF = 15;
  localparam int NODES             = 16;
  localparam int DIST_W            = 16;
  localparam int COST_W            = 21;
  localparam int ACC_W             = 40;
  localparam int CUST_W            = 4;

  localparam logic [1:0] FUNC_WR_DIST  = 2'd0;
  localparam logic [1:0] FUNC_WR_SLOT  = 2'd1;
  localparam logic [1:0] FUNC_MOVE     = 2'd2;
  localparam logic [1:0] FUNC_RD_BEST  = 2'd3;

  localparam logic [1:0] CFG_CUSTOMERS = 2'd0;
  localparam logic [1:0] CFG_ROUTES    = 2'd1;
  localparam logic [1:0] CFG_TEMP      = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [15:0] distance_value;
    logic [2:0]  route;
    logic [1:0]  slot;
    logic [3:0]  customer;
    logic [3:0]  accept_draw;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic        accepted;
    logic        improved;
    logic [20:0] new_cost;
    logic [3:0]  read_customer;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SIMPLE, ST_CHECK, ST_SEARCH, ST_BUILD,
    ST_COST, ST_DECIDE, ST_COMMIT, ST_BEST_COST, ST_FINISH, ST_OUT
  } state_t;

  // which route set is being costed
  typedef enum logic [1:0] {
    SET_CAND, SET_CUR, SET_BEST
  } cost_set_t;

  typedef struct packed {
    logic      simple_op;
    logic      check;
    logic      search_step;
    logic      build;
    logic      cost_start;
    cost_set_t cost_set;
    logic      decide;
    logic      commit;
    logic      best_check;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_move;
    logic bad;
    logic search_done;
    logic cost_done;
    logic accept;
  } dp_stat_t;

endpackage
`default_nettype wire

/* sv/arms_ram.sv */
`default_nettype none
module arms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* sv/arms_ctrl.sv */
`default_nettype none
module arms_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output arms_pkg::dp_cmd_t        cmd,
  input  wire arms_pkg::dp_stat_t  stat
);

  arms_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= arms_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.cost_set = arms_pkg::SET_CAND;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      arms_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = stat.is_move ? arms_pkg::ST_CHECK : arms_pkg::ST_SIMPLE;
        end
      end
      arms_pkg::ST_SIMPLE: begin
        cmd.simple_op = 1'b1;
        cmd.out_load  = 1'b1;
        state_nxt = arms_pkg::ST_OUT;
      end
      arms_pkg::ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = arms_pkg::ST_SEARCH;
      end
      arms_pkg::ST_SEARCH: begin
        cmd.search_step = 1'b1;
        if (stat.bad) begin
          cmd.out_load = 1'b1;
          state_nxt = arms_pkg::ST_OUT;
        end else if (stat.search_done) begin
          state_nxt = arms_pkg::ST_BUILD;
        end
      end
      arms_pkg::ST_BUILD: begin
        cmd.build = 1'b1;
        if (stat.bad) begin
          cmd.out_load = 1'b1;
          state_nxt = arms_pkg::ST_OUT;
        end else begin
          cmd.cost_start = 1'b1;
          cmd.cost_set = arms_pkg::SET_CAND;
          state_nxt = arms_pkg::ST_COST;
        end
      end
      arms_pkg::ST_COST: begin
        cmd.cost_set = arms_pkg::SET_CUR;
        if (stat.cost_done) begin
          cmd.cost_start = 1'b1;
          state_nxt = arms_pkg::ST_DECIDE;
        end
      end
      arms_pkg::ST_DECIDE: begin
        if (stat.cost_done) begin
          cmd.decide = 1'b1;
          state_nxt = arms_pkg::ST_COMMIT;
        end
      end
      arms_pkg::ST_COMMIT: begin
        cmd.cost_set = arms_pkg::SET_BEST;
        if (stat.accept) begin
          cmd.commit = 1'b1;
          cmd.cost_start = 1'b1;
          state_nxt = arms_pkg::ST_BEST_COST;
        end else begin
          cmd.out_load = 1'b1;
          state_nxt = arms_pkg::ST_OUT;
        end
      end
      arms_pkg::ST_BEST_COST: begin
        if (stat.cost_done) begin
          cmd.best_check = 1'b1;
          state_nxt = arms_pkg::ST_FINISH;
        end
      end
      arms_pkg::ST_FINISH: begin
        cmd.out_load = 1'b1;
        state_nxt = arms_pkg::ST_OUT;
      end
      arms_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = arms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = arms_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* sv/arms_dp.sv */
`default_nettype none
module arms_dp #(
  parameter int ROUTE_SLOTS   = arms_pkg::ROUTE_SLOTS_DEF,
  parameter int MAX_ROUTES    = arms_pkg::MAX_ROUTES_DEF,
  parameter int MAX_CUSTOMERS = arms_pkg::MAX_CUSTOMERS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_take,
  input  wire arms_pkg::in_item_t   in_data,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [15:0]          cfg_wdata,
  input  wire arms_pkg::dp_cmd_t    cmd,
  output arms_pkg::dp_stat_t        stat,
  output arms_pkg::out_item_t       out_data
);

  localparam int RW  = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
  localparam int SW  = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
  localparam int SCW = $clog2(ROUTE_SLOTS + 1);
  localparam int RCW = $clog2(MAX_ROUTES + 1);
  localparam int CW  = arms_pkg::CUST_W;
  localparam int AW  = arms_pkg::ACC_W;
  localparam logic [AW-1:0] COST_SAT = AW'((64'd1 << arms_pkg::COST_W) - 1);

  typedef logic [CW-1:0] slot_row_t [ROUTE_SLOTS];

  // configuration
  logic [3:0]  ccount_r;
  logic [3:0]  rcount_r;
  logic [15:0] temp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ccount_r <= 4'd15;
      rcount_r <= 4'd5;
      temp_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        arms_pkg::CFG_CUSTOMERS: ccount_r <= cfg_wdata[3:0];
        arms_pkg::CFG_ROUTES:    rcount_r <= cfg_wdata[3:0];
        arms_pkg::CFG_TEMP:      temp_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [RCW-1:0] nroutes;
  logic [5:0]     ccap;
  assign nroutes = (32'(rcount_r) > MAX_ROUTES) ? RCW'(MAX_ROUTES) : RCW'(rcount_r);
  assign ccap    = (32'(ccount_r) > MAX_CUSTOMERS) ? 6'(MAX_CUSTOMERS) : 6'(ccount_r);

  // item register
  arms_pkg::in_item_t item_r;
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= in_data;
    end
  end
  assign stat.is_move = (in_data.func == arms_pkg::FUNC_MOVE);

  // route storage
  logic [CW-1:0] cur_r  [MAX_ROUTES][ROUTE_SLOTS];
  logic [CW-1:0] best_r [MAX_ROUTES][ROUTE_SLOTS];
  logic [CW-1:0] cand_r [MAX_ROUTES][ROUTE_SLOTS];

  // distance memory
  logic [7:0]  d_raddr;
  logic [15:0] d_rdata;
  arms_ram #(.WIDTH(arms_pkg::DIST_W), .DEPTH(arms_pkg::NODES * arms_pkg::NODES)) u_dist (
    .clk   (clk),
    .we    (cmd.simple_op && item_r.func == arms_pkg::FUNC_WR_DIST),
    .waddr ({item_r.row, item_r.col}),
    .wdata (item_r.distance_value),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  logic          in_range;
  logic [RW-1:0] tgt;
  logic [SW-1:0] sl;
  assign in_range = (32'(item_r.route) < MAX_ROUTES) && (32'(item_r.slot) < ROUTE_SLOTS);
  assign tgt = RW'(item_r.route);
  assign sl  = SW'(item_r.slot);

  // search, one route per cycle
  logic [RW-1:0]  srch_r, src_r;
  logic [RCW-1:0] srch_cnt_r;
  logic           bad_r;
  logic           chk_bad;
  logic           row_hit;

  assign chk_bad = (item_r.accept_draw > 4'd9) || (item_r.customer == '0) ||
                   (6'(item_r.customer) > ccap) || (32'(item_r.route) >= 32'(nroutes));

  always_comb begin
    row_hit = 1'b0;
    for (int j = 0; j < ROUTE_SLOTS; j++) begin
      if (cur_r[srch_r][j] == item_r.customer) row_hit = 1'b1;
    end
  end

  logic search_bad;
  assign search_bad = bad_r || (!row_hit && (srch_cnt_r + 1'b1 >= nroutes)) ||
                      (row_hit && srch_r == tgt);
  assign stat.search_done = row_hit;

  // build candidate
  logic [SCW-1:0] tsize;
  logic           build_bad;
  slot_row_t      new_src, new_tgt;
  logic           done_f;
  logic [CW-1:0]  tmp;

  always_comb begin
    tsize = '0;
    for (int j = 0; j < ROUTE_SLOTS; j++) begin
      if (cur_r[tgt][j] != '0) tsize = tsize + 1'b1;
    end
    for (int j = 0; j < ROUTE_SLOTS; j++) begin
      new_src[j] = cur_r[src_r][j];
      new_tgt[j] = cur_r[tgt][j];
    end
    build_bad = 1'b0;
    done_f = 1'b0;
    tmp = '0;
    if (32'(tsize) < ROUTE_SLOTS) begin
      for (int j = 0; j < ROUTE_SLOTS; j++) begin
        if (!done_f && new_tgt[j] == '0) begin
          new_tgt[j] = item_r.customer;
          done_f = 1'b1;
        end
      end
      done_f = 1'b0;
      for (int j = 0; j < ROUTE_SLOTS; j++) begin
        if (!done_f && new_src[j] == item_r.customer) begin
          new_src[j] = '0;
          done_f = 1'b1;
        end
      end
      for (int j = 0; j + 1 < ROUTE_SLOTS; j++) begin
        if (new_src[j] == '0 && new_src[j+1] != '0) begin
          tmp = new_src[j+1];
          new_src[j] = tmp;
          new_src[j+1] = '0;
        end
      end
    end else begin
      if (32'(item_r.slot) >= ROUTE_SLOTS) begin
        build_bad = 1'b1;
      end else if (cur_r[tgt][sl] == '0) begin
        build_bad = 1'b1;
      end else begin
        for (int j = 0; j < ROUTE_SLOTS; j++) begin
          if (!done_f && new_src[j] == item_r.customer) begin
            new_src[j] = cur_r[tgt][sl];
            done_f = 1'b1;
          end
        end
        new_tgt[sl] = item_r.customer;
      end
    end
  end

  logic dp_bad;
  always_comb begin
    dp_bad = 1'b0;
    if (cmd.search_step) dp_bad = search_bad;
    if (cmd.build) dp_bad = build_bad;
  end
  assign stat.bad = dp_bad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bad_r <= 1'b0;
    end else if (cmd.check) begin
      bad_r <= chk_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      srch_r     <= '0;
      srch_cnt_r <= '0;
    end else if (cmd.search_step) begin
      if (row_hit) src_r <= srch_r;
      srch_r     <= RW'(srch_cnt_r + 1'b1);
      srch_cnt_r <= srch_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      cand_r <= cur_r;
    end else if (cmd.build) begin
      for (int j = 0; j < ROUTE_SLOTS; j++) begin
        cand_r[src_r][j] <= new_src[j];
        cand_r[tgt][j]   <= new_tgt[j];
      end
    end
  end

  // cost walker: at most one distance read a cycle
  // each step: slot j, phase 0 = link, phase 1 = depot return
  logic           cbusy_r, cvalid_r, cadd_r;
  arms_pkg::cost_set_t cset_r;
  logic [RW-1:0]  cr_r;
  logic [SW-1:0]  cs_r;
  logic           cph_r;
  logic [AW-1:0]  acc_r;
  logic           cost_fin_r;
  logic [CW-1:0]  c_cur, c_prev;
  logic           last_slot, last_route;
  logic [CW-1:0]  ra, rb;
  logic           use_read;
  logic           adv_route;

  function automatic logic [CW-1:0] pick(input arms_pkg::cost_set_t s,
      input logic [CW-1:0] a, input logic [CW-1:0] b, input logic [CW-1:0] c);
    logic [CW-1:0] v;
    case (s)
      arms_pkg::SET_CAND: v = a;
      arms_pkg::SET_CUR:  v = b;
      arms_pkg::SET_BEST: v = c;
      default:            v = a;
    endcase
    return v;
  endfunction

  always_comb begin
    c_cur  = pick(cset_r, cand_r[cr_r][cs_r], cur_r[cr_r][cs_r], best_r[cr_r][cs_r]);
    c_prev = '0;
    if (cs_r != '0) begin
      c_prev = pick(cset_r, cand_r[cr_r][cs_r - 1'b1], cur_r[cr_r][cs_r - 1'b1],
                    best_r[cr_r][cs_r - 1'b1]);
    end
    last_slot  = (32'(cs_r) == ROUTE_SLOTS - 1);
    last_route = (32'(cr_r) + 1 >= 32'(nroutes));
    ra = '0;
    rb = '0;
    use_read = 1'b0;
    if (!cph_r) begin
      if (c_cur == '0) begin
        if (c_prev != '0) begin
          ra = '0; rb = c_prev; use_read = 1'b1;
        end
      end else begin
        ra = c_prev; rb = c_cur; use_read = 1'b1;
      end
    end else begin
      ra = '0; rb = c_cur; use_read = 1'b1;
    end
    adv_route = last_slot && (cph_r || c_cur == '0);
  end

  assign d_raddr = {ra, rb};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cbusy_r    <= 1'b0;
      cvalid_r   <= 1'b0;
      cost_fin_r <= 1'b0;
      cadd_r     <= 1'b0;
    end else begin
      cvalid_r   <= cost_fin_r;
      cost_fin_r <= 1'b0;
      cadd_r     <= 1'b0;
      if (cmd.cost_start) begin
        cbusy_r  <= 1'b1;
        cvalid_r <= 1'b0;
        cset_r   <= cmd.cost_set;
        cr_r     <= '0;
        cs_r     <= '0;
        cph_r    <= 1'b0;
        acc_r    <= '0;
      end else if (cbusy_r) begin
        cadd_r <= use_read;
        if (adv_route) begin
          cph_r <= 1'b0;
          cs_r  <= '0;
          cr_r  <= cr_r + 1'b1;
          if (last_route) begin
            cbusy_r    <= 1'b0;
            cost_fin_r <= 1'b1;
          end
        end else if (last_slot && c_cur != '0) begin
          cph_r <= 1'b1;
        end else begin
          cs_r <= cs_r + 1'b1;
        end
      end
      if (cadd_r && !cmd.cost_start) begin
        acc_r <= acc_r + AW'(d_rdata);
      end
    end
  end
  // a zero route count is rejected before any costing starts
  assign stat.cost_done = cvalid_r;

  // decision, acc_r holds the current cost at decide
  logic [AW-1:0] newc_r;
  logic          acc_ok_r, impr_r;
  logic [AW-1:0] lhs, rhs;
  always_comb begin
    lhs = AW'(10) * (newc_r - acc_r);
    rhs = AW'(temp_r) * AW'(8'd10 * 8'(item_r.accept_draw) + 8'd1);
  end

  always_ff @(posedge clk) begin
    if (cmd.cost_start && cmd.cost_set == arms_pkg::SET_CUR) newc_r <= acc_r;
    if (cmd.check) begin
      acc_ok_r <= 1'b0;
      impr_r   <= 1'b0;
    end
    if (cmd.decide) begin
      acc_ok_r <= (newc_r < acc_r) || (lhs < rhs);
    end
    if (cmd.best_check) impr_r <= (newc_r < acc_r);
  end
  assign stat.accept = acc_ok_r;

  // route updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_ROUTES; i++) begin
        for (int j = 0; j < ROUTE_SLOTS; j++) begin
          cur_r[i][j]  <= '0;
          best_r[i][j] <= '0;
        end
      end
    end else begin
      if (cmd.simple_op && item_r.func == arms_pkg::FUNC_WR_SLOT && in_range) begin
        cur_r[tgt][sl]  <= item_r.customer;
        best_r[tgt][sl] <= item_r.customer;
      end
      if (cmd.commit) cur_r <= cand_r;
      if (cmd.best_check && newc_r < acc_r) best_r <= cand_r;
    end
  end

  // result register
  arms_pkg::out_item_t out_nxt;
  always_comb begin
    out_nxt = '0;
    if (cmd.simple_op) begin
      if (item_r.func == arms_pkg::FUNC_RD_BEST && in_range) begin
        out_nxt.read_customer = best_r[tgt][sl];
      end
    end else if (dp_bad) begin
      out_nxt.status = 1'b1;
    end else begin
      out_nxt.accepted = acc_ok_r;
      out_nxt.improved = impr_r;
      out_nxt.new_cost = arms_pkg::COST_W'((newc_r > COST_SAT) ? COST_SAT : newc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= out_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/annealing_route_move_step_unit.sv */
// Simulated-annealing move step for a small vehicle-routing problem. Each
// transfer carries one command: write distance, write route slot, move, or
// read best slot; each gives exactly one result. Simple commands execute
// after the accept and then present their result. A move checks the draw,
// scans routes one per cycle, builds the candidate, then costs the
// candidate, the current and (if accepted) the best routes through the
// single distance RAM read port, at most one read per cycle. Configuration
// writes only while idle: the user must keep to this, as the block itself
// does not enforce it.
`default_nettype none
module annealing_route_move_step_unit #(
  parameter int ROUTE_SLOTS   = arms_pkg::ROUTE_SLOTS_DEF,
  parameter int MAX_ROUTES    = arms_pkg::MAX_ROUTES_DEF,
  parameter int MAX_CUSTOMERS = arms_pkg::MAX_CUSTOMERS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire arms_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output arms_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [15:0]         cfg_wdata
);

  arms_pkg::dp_cmd_t  cmd;
  arms_pkg::dp_stat_t stat;

  arms_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .stat
  );

  arms_dp #(
    .ROUTE_SLOTS(ROUTE_SLOTS), .MAX_ROUTES(MAX_ROUTES), .MAX_CUSTOMERS(MAX_CUSTOMERS)
  ) u_dp (
    .clk, .rst_n,
    .in_take (in_valid && !in_stall),
    .in_data, .cfg_we, .cfg_index, .cfg_wdata, .cmd, .stat, .out_data
  );

endmodule
`default_nettype wire

/* sv/arms_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module arms_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire arms_pkg::out_item_t out_data
);

  `ARMS_ASSERT_IMPL(a_no_in_while_out, clk, rst_n, out_valid, in_stall, "input taken with result pending")
  `ARMS_ASSERT_NEXT(a_take_stalls, clk, rst_n, in_valid && !in_stall, in_stall, "second input taken while busy")
  `ARMS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `ARMS_ASSERT_IMPL(a_status_clean, clk, rst_n, out_valid && out_data.status, !out_data.accepted && out_data.new_cost == '0, "invalid move carries results")
  `ARMS_ASSERT_IMPL(a_improve_acc, clk, rst_n, out_valid && out_data.improved, out_data.accepted, "improved without accept")

endmodule
bind annealing_route_move_step_unit arms_checker u_arms_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);
`default_nettype wire
